FILE: rtl/core/tmw_pkg.sv
// tmw_pkg: shared types and constants of the tcp option mss walker
// used by tmw_step, tcp_option_mss_walker_core and tmw_checker
// no dependencies
`default_nettype none

package tmw_pkg;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_KIND   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_MSS_HI = 6'b000100,
    PH_MSS_LO = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_e;

  // option kinds
  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  // fixed skip sizes
  localparam logic [7:0] WSCALE_SKIP = 8'd1;
  localparam logic [7:0] TSTAMP_SKIP = 8'd8;
  localparam logic [7:0] OPT_HDR_LEN = 8'd2;

  // walk status codes
  localparam logic [1:0] STATUS_WALK = 2'd0;
  localparam logic [1:0] STATUS_END  = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // register index (byte address bit 2)
  localparam logic REG_NEW_MSS = 1'b0;
  localparam logic REG_REWRITE = 1'b1;

  localparam logic [15:0] NEW_MSS_RESET = 16'd1460;
  localparam logic [5:0]  POS_MAX       = 6'd63;

  // walk state carried from byte to byte
  typedef struct packed {
    logic [5:0]  pos;
    phase_e      phase;
    logic [7:0]  kind;
    logic [7:0]  skip;
    logic [15:0] mss;
    logic        mss_flag;
    logic [1:0]  status;
  } walk_state_t;

  localparam walk_state_t WALK_RESET = '{
    pos:      6'd0,
    phase:    PH_KIND,
    kind:     8'd0,
    skip:     8'd0,
    mss:      16'd0,
    mss_flag: 1'b0,
    status:   STATUS_WALK
  };

  // one result item
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        mss_found;
    logic [15:0] mss_seen;
    logic [1:0]  walk_status;
    logic        last_out;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcp_option_mss_walker_core.sv
// tcp_option_mss_walker_core: tcp option walker with mss report and rewrite
// an accepted byte passes the input register, then the result register, before result valid
// throughput: one byte per cycle unless out_ready stalls, set by the combinational tmw_step
// in_ready follows out_ready through the advance term, a full pipe stalls its input
// reset: async active low, clears the walk state, new_mss to 1460, rewrite off
// depends on tmw_pkg and tmw_step
`default_nettype none

module tcp_option_mss_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  opt_byte_i,
  input  logic [5:0]  area_len_i,
  input  logic        last_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic        mss_found_o,
  output logic [15:0] mss_seen_o,
  output logic [1:0]  walk_status_o,
  output logic        last_out_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic [5:0]  s1_alen_q;
  logic        s1_last_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        in_req;
  logic        cfg_wr;
  logic [15:0] new_mss_q;
  logic        rewrite_q;

  tmw_pkg::walk_state_t state_q, state_d;
  tmw_pkg::result_t     result_d, result_q;

  // handshake and pipeline advance
  assign in_req     = in_valid_i & in_ready_o;
  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_req) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= tmw_pkg::WALK_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      s1_byte_q <= opt_byte_i;
      s1_alen_q <= area_len_i;
      s1_last_q <= last_in_i;
    end
  end

  // walk update
  tmw_step u_step (
    .state_i    (state_q),
    .opt_byte_i (s1_byte_q),
    .area_len_i (s1_alen_q),
    .last_in_i  (s1_last_q),
    .new_mss_i  (new_mss_q),
    .rewrite_i  (rewrite_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) result_q <= result_d;
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = result_q.byte_out;
  assign mss_found_o   = result_q.mss_found;
  assign mss_seen_o    = result_q.mss_seen;
  assign walk_status_o = result_q.walk_status;
  assign last_out_o    = result_q.last_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_mss_q <= tmw_pkg::NEW_MSS_RESET;
      rewrite_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tmw_pkg::REG_NEW_MSS: new_mss_q <= pwdata[15:0];
        tmw_pkg::REG_REWRITE: rewrite_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back, low address bits ignored
  always_comb begin
    unique case (paddr[2])
      tmw_pkg::REG_NEW_MSS: prdata = {16'd0, new_mss_q};
      tmw_pkg::REG_REWRITE: prdata = {31'd0, rewrite_q};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tmw_step.sv
// tmw_step: next walk state and result for one option byte
// depends on tmw_pkg
`default_nettype none

module tmw_step (
  input  tmw_pkg::walk_state_t state_i,
  input  logic [7:0]           opt_byte_i,
  input  logic [5:0]           area_len_i,
  input  logic                 last_in_i,
  input  logic [15:0]          new_mss_i,
  input  logic                 rewrite_i,
  output tmw_pkg::walk_state_t state_o,
  output tmw_pkg::result_t     result_o
);

  tmw_pkg::walk_state_t nxt;
  logic [7:0] bout;
  logic       active;
  logic [8:0] ext_end;
  logic [8:0] ext_lim;
  logic [7:0] skip_dec;
  logic [7:0] skip_len;

  // option extent and skip arithmetic
  assign active   = (state_i.phase != tmw_pkg::PH_STOP) && (state_i.pos < area_len_i);
  assign ext_end  = {3'b000, state_i.pos} + {1'b0, opt_byte_i};
  assign ext_lim  = {3'b000, area_len_i} + 9'd1;
  assign skip_dec = (state_i.skip != 8'd0) ? state_i.skip - 8'd1 : state_i.skip;
  assign skip_len = opt_byte_i - tmw_pkg::OPT_HDR_LEN;

  // phase update
  always_comb begin
    nxt  = state_i;
    bout = opt_byte_i;
    if (active) begin
      unique case (state_i.phase)
        tmw_pkg::PH_LEN: begin
          if (ext_end > ext_lim) begin
            nxt.status = tmw_pkg::STATUS_BAD;
            nxt.phase  = tmw_pkg::PH_STOP;
          end else if (state_i.kind == tmw_pkg::KIND_MSS) begin
            nxt.phase = tmw_pkg::PH_MSS_HI;
          end else if (state_i.kind == tmw_pkg::KIND_WSCALE) begin
            nxt.skip  = tmw_pkg::WSCALE_SKIP;
            nxt.phase = tmw_pkg::PH_SKIP;
          end else if (state_i.kind == tmw_pkg::KIND_SACKOK) begin
            nxt.phase = tmw_pkg::PH_KIND;
          end else if (state_i.kind == tmw_pkg::KIND_TSTAMP) begin
            nxt.skip  = tmw_pkg::TSTAMP_SKIP;
            nxt.phase = tmw_pkg::PH_SKIP;
          end else if (opt_byte_i < tmw_pkg::OPT_HDR_LEN) begin
            nxt.status = tmw_pkg::STATUS_BAD;
            nxt.phase  = tmw_pkg::PH_STOP;
          end else begin
            nxt.skip  = skip_len;
            nxt.phase = (skip_len != 8'd0) ? tmw_pkg::PH_SKIP : tmw_pkg::PH_KIND;
          end
        end
        tmw_pkg::PH_MSS_HI: begin
          nxt.skip  = opt_byte_i;
          nxt.phase = tmw_pkg::PH_MSS_LO;
          if (rewrite_i) bout = new_mss_i[15:8];
        end
        tmw_pkg::PH_MSS_LO: begin
          nxt.mss      = {state_i.skip, opt_byte_i};
          nxt.mss_flag = 1'b1;
          nxt.skip     = 8'd0;
          nxt.phase    = tmw_pkg::PH_KIND;
          if (rewrite_i) bout = new_mss_i[7:0];
        end
        tmw_pkg::PH_SKIP: begin
          nxt.skip = skip_dec;
          if (skip_dec == 8'd0) nxt.phase = tmw_pkg::PH_KIND;
        end
        default: begin
          if (opt_byte_i == tmw_pkg::KIND_END) begin
            nxt.status = tmw_pkg::STATUS_END;
            nxt.phase  = tmw_pkg::PH_STOP;
          end else if (opt_byte_i != tmw_pkg::KIND_NOP) begin
            nxt.kind  = opt_byte_i;
            nxt.phase = tmw_pkg::PH_LEN;
          end else begin
            nxt.phase = tmw_pkg::PH_KIND;
          end
        end
      endcase
    end
  end

  // result reflects the state after this byte
  assign result_o.byte_out    = bout;
  assign result_o.mss_found   = nxt.mss_flag;
  assign result_o.mss_seen    = nxt.mss;
  assign result_o.walk_status = nxt.status;
  assign result_o.last_out    = last_in_i;

  // position count and area end clear
  always_comb begin
    state_o = nxt;
    if (state_i.pos != tmw_pkg::POS_MAX) state_o.pos = state_i.pos + 6'd1;
    if (last_in_i) state_o = tmw_pkg::WALK_RESET;
  end

endmodule

`default_nettype wire

FILE: rtl/core/tmw_checker.sv
// tmw_checker: port-level checks of tcp_option_mss_walker_core
// depends on tmw_pkg; bound to the top level below
`default_nettype none

module tmw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  byte_out_o,
  input logic        mss_found_o,
  input logic [15:0] mss_seen_o,
  input logic [1:0]  walk_status_o,
  input logic        last_out_o
);

  logic       out_req;
  logic       prev_valid_q;
  logic       prev_last_q;
  logic       prev_found_q;
  logic [1:0] prev_status_q;

  assign out_req = out_valid_o & out_ready_i;

  // remember the previous delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q  <= 1'b0;
      prev_last_q   <= 1'b0;
      prev_found_q  <= 1'b0;
      prev_status_q <= tmw_pkg::STATUS_WALK;
    end else if (out_req) begin
      prev_valid_q  <= 1'b1;
      prev_last_q   <= last_out_o;
      prev_found_q  <= mss_found_o;
      prev_status_q <= walk_status_o;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o)
      && $stable(mss_seen_o) && $stable(walk_status_o) && $stable(last_out_o))
    else $error("result changed while stalled");

  // status is a known code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> walk_status_o == tmw_pkg::STATUS_WALK
      || walk_status_o == tmw_pkg::STATUS_END || walk_status_o == tmw_pkg::STATUS_BAD)
    else $error("walk status out of range");

  // no mss value reported before one was found
  a_mss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mss_found_o |-> mss_seen_o == 16'd0)
    else $error("mss value without mss found");

  // a stop sticks until the area ends
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prev_valid_q && !prev_last_q && prev_status_q != tmw_pkg::STATUS_WALK
      |-> walk_status_o == prev_status_q)
    else $error("stop status changed inside an area");

  // mss found sticks until the area ends
  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prev_valid_q && !prev_last_q && prev_found_q |-> mss_found_o)
    else $error("mss found dropped inside an area");

endmodule

bind tcp_option_mss_walker_core tmw_checker u_tmw_checker (.*);

`default_nettype wire
